FILE: rtl/lgpp_pkg.sv
`default_nettype none

package lgpp_pkg;

    localparam int HALF_LINES       = 32;
    localparam int HALF_WORD_OFFSET = 8;

    localparam int LINE_W  = 5;
    localparam int WORD_W  = 4;
    localparam int ADDR_W  = LINE_W + WORD_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int DATA_W  = 16;
    localparam int X_W     = 7;
    localparam int Y_W     = 6;
    localparam int YE_W    = Y_W + 1;
    localparam int WSUM_W  = WORD_W + 1;

    typedef enum logic [1:0] {
        MODE_CLR  = 2'd0,
        MODE_SET  = 2'd1,
        MODE_TOG  = 2'd2,
        MODE_KEEP = 2'd3
    } mode_t;

    typedef enum logic {
        FUNC_PLOT  = 1'b0,
        FUNC_CLEAR = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic load;
        logic sweep_we;
        logic rmw_we;
        logic ack;
    } lgpp_cmd_t;

    typedef struct packed {
        logic sweep_last;
    } lgpp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/lgpp_ctrl.sv
`default_nettype none

module lgpp_ctrl
    import lgpp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic      func,
    input  wire lgpp_sts_t sts,
    output lgpp_cmd_t      cmd,
    output logic           busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_we = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (func == FUNC_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.rmw_we = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                cmd.sweep_we = 1'b1;
                if (sts.sweep_last)
                begin
                    cmd.ack    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/lgpp_dp.sv
`default_nettype none

module lgpp_dp
    import lgpp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lgpp_cmd_t         cmd,
    input  wire logic [X_W-1:0]    x_pos,
    input  wire logic [Y_W-1:0]    y_pos,
    input  wire logic [1:0]        mode,
    output lgpp_sts_t              sts,
    output logic                   done,
    output logic [LINE_W-1:0]      line_addr,
    output logic [WORD_W-1:0]      word_addr,
    output logic [DATA_W-1:0]      word_data,
    output logic                   cleared
);

    localparam logic [YE_W-1:0]   HALF_LINES_C = YE_W'(HALF_LINES);
    localparam logic [WSUM_W-1:0] OFFSET_C     = WSUM_W'(HALF_WORD_OFFSET);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [ADDR_W-1:0] sweep_reg;
    logic [LINE_W-1:0] line_reg;
    logic [WORD_W-1:0] word_reg;
    logic [3:0]        bit_reg;
    mode_t             mode_reg;
    logic [DATA_W-1:0] rd_data_reg;

    logic              done_reg;
    logic [LINE_W-1:0] line_out_reg;
    logic [WORD_W-1:0] word_out_reg;
    logic [DATA_W-1:0] data_out_reg;
    logic              cleared_reg;

    logic [YE_W-1:0]   y_ext;
    logic [YE_W-1:0]   y_fold;
    logic [WSUM_W-1:0] w_sum;
    logic [LINE_W-1:0] line_next;
    logic [WORD_W-1:0] word_next;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] new_word;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    // fold the lower screen half into the right-hand words
    always_comb
    begin
        y_ext = YE_W'(y_pos);
        w_sum = WSUM_W'(x_pos[X_W-1:4]);
        if (y_ext < HALF_LINES_C)
        begin
            y_fold = y_ext;
        end
        else
        begin
            y_fold = y_ext - HALF_LINES_C;
            w_sum  = w_sum + OFFSET_C;
        end
        line_next = y_fold[LINE_W-1:0];
        word_next = w_sum[WORD_W-1:0];
    end

    // msb first: pixel 0 of a word is bit 15
    always_comb
    begin
        mask = {1'b1, {(DATA_W-1){1'b0}}} >> bit_reg;
        unique case (mode_reg)
            MODE_CLR:  new_word = rd_data_reg & ~mask;
            MODE_SET:  new_word = rd_data_reg | mask;
            MODE_TOG:  new_word = rd_data_reg ^ mask;
            MODE_KEEP: new_word = rd_data_reg;
            default:   new_word = rd_data_reg;
        endcase
    end

    assign mem_we    = cmd.sweep_we | cmd.rmw_we;
    assign mem_waddr = cmd.sweep_we ? sweep_reg : {line_reg, word_reg};
    assign mem_wdata = cmd.sweep_we ? '0 : new_word;

    assign sts.sweep_last = (sweep_reg == ADDR_W'(DEPTH - 1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[{line_reg, word_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            line_reg <= line_next;
            word_reg <= word_next;
            bit_reg  <= x_pos[3:0];
            mode_reg <= mode_t'(mode);
        end
        if (cmd.rmw_we)
        begin
            line_out_reg <= line_reg;
            word_out_reg <= word_reg;
            data_out_reg <= new_word;
            cleared_reg  <= 1'b0;
        end
        else if (cmd.ack)
        begin
            line_out_reg <= '0;
            word_out_reg <= '0;
            data_out_reg <= '0;
            cleared_reg  <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.sweep_we)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            done_reg <= cmd.rmw_we | cmd.ack;
        end
    end

    assign done      = done_reg;
    assign line_addr = line_out_reg;
    assign word_addr = word_out_reg;
    assign word_data = data_out_reg;
    assign cleared   = cleared_reg;

endmodule

`default_nettype wire

FILE: rtl/lcd_gdram_pixel_plotter_unit.sv
// channel   ports                                   handshake
// -------   -------------------------------------   -------------------------
// command   func x_pos y_pos mode                   start high, busy low
// result    line_addr word_addr word_data cleared   done high for one cycle
//
// plot: accept, then read, modify-write and the result register before done
// clear: accept, then a 512-word sweep and the result register before done
// after reset busy stays high for a 512-word zeroing sweep of the store
// a new command is taken in the cycle done is shown; results cannot stall
`default_nettype none

module lcd_gdram_pixel_plotter_unit
    import lgpp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              func,
    input  wire logic [X_W-1:0]    x_pos,
    input  wire logic [Y_W-1:0]    y_pos,
    input  wire logic [1:0]        mode,
    output logic                   done,
    output logic [LINE_W-1:0]      line_addr,
    output logic [WORD_W-1:0]      word_addr,
    output logic [DATA_W-1:0]      word_data,
    output logic                   cleared
);

    lgpp_cmd_t cmd;
    lgpp_sts_t sts;

    lgpp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    lgpp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .mode      (mode),
        .sts       (sts),
        .done      (done),
        .line_addr (line_addr),
        .word_addr (word_addr),
        .word_data (word_data),
        .cleared   (cleared)
    );

endmodule

`default_nettype wire

FILE: rtl/lgpp_chk.sv
`default_nettype none

module lgpp_chk
    import lgpp_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              func,
    input wire logic [X_W-1:0]    x_pos,
    input wire logic [Y_W-1:0]    y_pos,
    input wire logic [1:0]        mode,
    input wire logic              done,
    input wire logic [LINE_W-1:0] line_addr,
    input wire logic [WORD_W-1:0] word_addr,
    input wire logic [DATA_W-1:0] word_data,
    input wire logic              cleared
);

    // accepted beat keeps the unit busy for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // one result beat per command, never two in a row
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back to back result beats");

    // a result only follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without work");

    // clear acknowledge carries zero address and data
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && cleared) |-> (line_addr == '0 && word_addr == '0 && word_data == '0))
        else $error("clear acknowledge not zero");

endmodule

bind lcd_gdram_pixel_plotter_unit lgpp_chk u_lgpp_chk (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lgpp_pkg::*;

    localparam int CYCLE_LIMIT = 2500000;
    localparam int FRAME_WORDS = 1 << (LINE_W + WORD_W);

    typedef struct {
        logic [LINE_W-1:0] line_no;
        logic [WORD_W-1:0] word_no;
        logic [DATA_W-1:0] pixels;
        logic              is_clear;
    } gdram_write_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              func = 1'b0;
    logic [X_W-1:0]    x_pos = '0;
    logic [Y_W-1:0]    y_pos = '0;
    logic [1:0]        mode = '0;
    logic              busy;
    logic              done;
    logic [LINE_W-1:0] line_addr;
    logic [WORD_W-1:0] word_addr;
    logic [DATA_W-1:0] word_data;
    logic              cleared;

    logic [DATA_W-1:0] frame_shadow [FRAME_WORDS];
    gdram_write_t      pending_writes [$];
    int                error_count = 0;
    int                cycle_count = 0;
    int                burst_left = 0;

    lcd_gdram_pixel_plotter_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .mode      (mode),
        .done      (done),
        .line_addr (line_addr),
        .word_addr (word_addr),
        .word_data (word_data),
        .cleared   (cleared)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        foreach (frame_shadow[i])
        begin
            frame_shadow[i] = '0;
        end
    end

    function automatic gdram_write_t predict_gdram_write(input func_t f,
                                                         input logic [X_W-1:0] x,
                                                         input logic [Y_W-1:0] y,
                                                         input mode_t m);
        gdram_write_t      w;
        logic [LINE_W-1:0] line_sel;
        logic [WORD_W-1:0] word_sel;
        logic [3:0]        pix_sel;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] data;
        if (f == FUNC_CLEAR)
        begin
            foreach (frame_shadow[i])
            begin
                frame_shadow[i] = '0;
            end
            w.line_no  = '0;
            w.word_no  = '0;
            w.pixels   = '0;
            w.is_clear = 1'b1;
            return w;
        end
        word_sel = WORD_W'(x[X_W-1:4]);
        if (y < HALF_LINES)
        begin
            line_sel = LINE_W'(y);
        end
        else
        begin
            line_sel = LINE_W'(y - HALF_LINES);
            word_sel = WORD_W'(word_sel + HALF_WORD_OFFSET);
        end
        // msb first: pixel 0 of the word sits in bit 15
        pix_sel = 4'd15 - x[3:0];
        mask = DATA_W'(1) << pix_sel;
        data = frame_shadow[{line_sel, word_sel}];
        case (m)
            MODE_CLR: data = data & ~mask;
            MODE_SET: data = data | mask;
            MODE_TOG: data = data ^ mask;
            default:  data = data;
        endcase
        frame_shadow[{line_sel, word_sel}] = data;
        w.line_no  = line_sel;
        w.word_no  = word_sel;
        w.pixels   = data;
        w.is_clear = 1'b0;
        return w;
    endfunction

    always @(posedge clk)
    begin
        gdram_write_t want;
        if (rst_n && done)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("unexpected beat: line_addr %0d word_addr %0d word_data %h cleared %b",
                       line_addr, word_addr, word_data, cleared);
                error_count++;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (line_addr !== want.line_no)
                begin
                    $error("line_addr expected %0d actual %0d", want.line_no, line_addr);
                    error_count++;
                end
                if (word_addr !== want.word_no)
                begin
                    $error("word_addr expected %0d actual %0d", want.word_no, word_addr);
                    error_count++;
                end
                if (word_data !== want.pixels)
                begin
                    $error("word_data expected %h actual %h", want.pixels, word_data);
                    error_count++;
                end
                if (cleared !== want.is_clear)
                begin
                    $error("cleared expected %b actual %b", want.is_clear, cleared);
                    error_count++;
                end
            end
        end
    end

    task automatic send_beat(input func_t f, input logic [X_W-1:0] x,
                             input logic [Y_W-1:0] y, input mode_t m);
        start <= 1'b1;
        func  <= f;
        x_pos <= x;
        y_pos <= y;
        mode  <= m;
        do @(posedge clk); while (busy);
        pending_writes.push_back(predict_gdram_write(f, x, y, m));
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        func  <= 1'($urandom);
        x_pos <= X_W'($urandom);
        y_pos <= Y_W'($urandom);
        mode  <= 2'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_all_written();
        start <= 1'b0;
        do @(posedge clk); while (pending_writes.size() != 0);
    endtask

    task automatic pace_sender();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
            begin
                idle_gap($urandom_range(1, 6));
            end
        end
        burst_left--;
    endtask

    function automatic mode_t any_mode();
        return mode_t'(2'($urandom_range(0, 3)));
    endfunction

    task automatic test_edge_pixels();
        send_beat(FUNC_PLOT, 7'd0,   6'd0,  MODE_SET);
        send_beat(FUNC_PLOT, 7'd127, 6'd0,  MODE_SET);
        send_beat(FUNC_PLOT, 7'd127, 6'd63, MODE_SET);
        send_beat(FUNC_PLOT, 7'd0,   6'd32, MODE_SET);
        send_beat(FUNC_PLOT, 7'd0,   6'd31, MODE_SET);
        send_beat(FUNC_PLOT, 7'd64,  6'd63, MODE_TOG);
        send_beat(FUNC_PLOT, 7'd64,  6'd63, MODE_TOG);
        // keep still reports the word as read
        send_beat(FUNC_PLOT, 7'd1,   6'd0,  MODE_KEEP);
        send_beat(FUNC_PLOT, 7'd1,   6'd0,  MODE_SET);
        send_beat(FUNC_PLOT, 7'd0,   6'd0,  MODE_CLR);
        send_beat(FUNC_PLOT, 7'd15,  6'd0,  MODE_TOG);
        send_beat(FUNC_PLOT, 7'd16,  6'd0,  MODE_SET);
        send_beat(FUNC_PLOT, 7'd127, 6'd63, MODE_CLR);
        send_beat(FUNC_PLOT, 7'd5,   6'd40, MODE_SET);
        send_beat(FUNC_CLEAR, 7'd5,  6'd40, MODE_SET);
        send_beat(FUNC_PLOT, 7'd5,   6'd40, MODE_TOG);
        send_beat(FUNC_PLOT, 7'd0,   6'd0,  MODE_KEEP);
        send_beat(FUNC_PLOT, 7'd127, 6'd31, MODE_KEEP);
        send_beat(FUNC_PLOT, 7'd85,  6'd42, MODE_SET);
        send_beat(FUNC_CLEAR, 7'd127, 6'd63, MODE_KEEP);
        send_beat(FUNC_PLOT, 7'd85,  6'd42, MODE_KEEP);
        send_beat(FUNC_PLOT, 7'd42,  6'd21, MODE_CLR);
    endtask

    // many hits on a few words so back-to-back read-modify-writes collide
    task automatic test_word_hammer();
        logic [2:0]     word_hi;
        logic [Y_W-1:0] row;
        logic [Y_W-1:0] y;
        for (int i = 0; i < 300; i++)
        begin
            if (i % 30 == 0)
            begin
                word_hi = 3'($urandom);
                row = Y_W'($urandom);
            end
            y = ($urandom_range(0, 4) == 0) ? (row ^ 6'd1) : row;
            pace_sender();
            if ($urandom_range(0, 99) == 0)
            begin
                send_beat(FUNC_CLEAR, X_W'($urandom), Y_W'($urandom), any_mode());
            end
            else
            begin
                send_beat(FUNC_PLOT, {word_hi, 4'($urandom)}, y, any_mode());
            end
        end
    endtask

    task automatic test_random_mix();
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        x = '0;
        y = '0;
        for (int i = 0; i < 480; i++)
        begin
            if (i == 240)
            begin
                wait_all_written();
            end
            pace_sender();
            if ($urandom_range(0, 99) < 3)
            begin
                send_beat(FUNC_CLEAR, X_W'($urandom), Y_W'($urandom), any_mode());
            end
            else
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    x = X_W'($urandom);
                    y = Y_W'($urandom);
                end
                send_beat(FUNC_PLOT, x, y, any_mode());
            end
        end
    endtask

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_pixels();
        wait_all_written();
        test_word_hammer();
        test_random_mix();
        wait_all_written();
        repeat (16) @(posedge clk);
        if (error_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
